### rtl/message_flit_segmenter_top_macros.svh
// Assertion macros shared by the message flit segmenter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MESSAGE_FLIT_SEGMENTER_TOP_MACROS_SVH
`define MESSAGE_FLIT_SEGMENTER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define MFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mfs_pkg.sv
// Package for the message flit segmenter: word types, register indexes,
// status codes and controller/datapath command and status structs.
`timescale 1ns / 1ps

package mfs_pkg;

	localparam int NODES_DEF         = 64;
	localparam int CLASSES_DEF       = 2;
	localparam int MAX_MSG_FLITS_DEF = 64;

	// flit counts fit 7 bits (message holds at most 64 flits)
	localparam int CNT_W  = 7;
	localparam int STEP_W = $clog2(CNT_W);
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_FLIT_BYTES    = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_PKT_FLITS = 3'd1;
	localparam logic [IDX_W-1:0] REG_PRIO_MODE     = 3'd2;
	localparam logic [IDX_W-1:0] REG_CLASS0_PRIO   = 3'd3;
	localparam logic [IDX_W-1:0] REG_CLASS1_PRIO   = 3'd4;
	localparam logic [IDX_W-1:0] REG_WRITE_MARK    = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DST  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	localparam logic [1:0] PRIO_CLASS = 2'd0;
	localparam logic [1:0] PRIO_AGE   = 2'd1;
	localparam logic [1:0] PRIO_SEQ   = 2'd2;
	localparam logic [1:0] PRIO_ZERO  = 2'd3;

	typedef struct packed {
		logic [5:0]  src_node;
		logic [6:0]  dst_node;
		logic [15:0] payload_len;
		logic        traffic_class;
		logic [30:0] inject_time;
		logic [30:0] source_seq;
	} mfs_in_t;

	typedef struct packed {
		logic [31:0] flit_id;
		logic [31:0] packet_id;
		logic [5:0]  out_src;
		logic [5:0]  out_dst;
		logic        out_class;
		logic [3:0]  flit_flags;
		logic [6:0]  packet_flits;
		logic [30:0] flit_priority;
		logic        is_write;
		logic [30:0] created_time;
		logic [1:0]  status;
	} mfs_out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic prep;
		logic emit;
		logic emit_err;
	} mfs_cmd_t;

	typedef struct packed {
		logic err;
		logic last;
		logic out_free;
	} mfs_sts_t;

endpackage

### rtl/mfs_ctrl.sv
// Controller FSM of the message flit segmenter: sequences accept, divide,
// setup and per-flit emission. Uses mfs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "message_flit_segmenter_top_macros.svh"

module mfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mfs_pkg::mfs_sts_t sts,
	output mfs_pkg::mfs_cmd_t cmd
);

	typedef enum logic [4:0] {
		IDLE = 5'b00001,
		DIV  = 5'b00010,
		PREP = 5'b00100,
		EMIT = 5'b01000,
		ERR  = 5'b10000
	} state_t;

	state_t                     st_q, st_d;
	logic [mfs_pkg::STEP_W-1:0] step_q;
	logic                       step_last;

	assign step_last = (step_q == mfs_pkg::STEP_W'(mfs_pkg::CNT_W - 1));
	assign in_stall  = (st_q != IDLE);

	always_comb begin
		st_d         = st_q;
		cmd          = '0;
		case (st_q)
			IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d     = DIV;
				end
			end
			DIV: begin
				cmd.step = 1'b1;
				if (step_last) begin
					st_d = sts.err ? ERR : PREP;
				end
			end
			PREP: begin
				cmd.prep = 1'b1;
				st_d     = EMIT;
			end
			EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last) st_d = IDLE;
				end
			end
			ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					st_d         = IDLE;
				end
			end
			default: st_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= IDLE;
			step_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == DIV) step_q <= step_last ? '0 : step_q + 1'b1;
			else step_q <= '0;
		end
	end

	`MFS_ASSERT_NXT(a_accept_to_div, clk, arst_n, cmd.load, st_q == DIV, "accept did not start divide")
	`MFS_ASSERT_NXT(a_err_skips_emit, clk, arst_n, st_q == DIV && step_last && sts.err, st_q == ERR, "error message entered flit emission")
	`MFS_ASSERT_IMP(a_emit_needs_slot, clk, arst_n, cmd.emit || cmd.emit_err, sts.out_free && (st_q == EMIT || st_q == ERR), "word issued without free output slot")

endmodule

### rtl/mfs_datapath.sv
// Datapath of the message flit segmenter: config registers, input latch,
// flit-count divider, packet/flit counters and output register. Uses mfs_pkg.
`timescale 1ns / 1ps
`include "message_flit_segmenter_top_macros.svh"

module mfs_datapath #(
	parameter int NODES         = mfs_pkg::NODES_DEF,
	parameter int CLASSES       = mfs_pkg::CLASSES_DEF,
	parameter int MAX_MSG_FLITS = mfs_pkg::MAX_MSG_FLITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mfs_pkg::IDX_W-1:0] cfg_index,
	input  logic [mfs_pkg::CFG_W-1:0] cfg_wdata,
	input  mfs_pkg::mfs_in_t          in_data,
	input  mfs_pkg::mfs_cmd_t         cmd,
	output mfs_pkg::mfs_sts_t         sts,
	input  logic                      out_stall,
	output logic                      out_valid,
	output mfs_pkg::mfs_out_t         out_data
);

	localparam int CW = mfs_pkg::CNT_W;

	// configuration
	logic [6:0]  flit_bytes_q, max_pkt_q;
	logic [1:0]  prio_mode_q;
	logic [15:0] class0_prio_q, class1_prio_q;
	logic        write_mark_q;

	// message latch
	logic [5:0]  src_q;
	logic [5:0]  dst_q;
	logic        cls_q;
	logic [30:0] time_q, pri_q;
	logic [1:0]  status_q;
	logic        zero_q;

	// divider
	logic [CW-1:0] dvd_q, quo_q;
	logic [CW-1:0] prem_q;

	// emission
	logic [CW-1:0] rem_q, pkt_left_q;
	logic          pkt_tail_q, pkt_head_q;
	logic [31:0]   pid_q, next_pid_q, next_fid_q;

	mfs_pkg::mfs_out_t out_q;
	logic              out_valid_q;

	logic [6:0]  fb_eff, mp_eff;
	logic        bad_dst, too_long, cls_sel;
	logic [15:0] max_bytes;
	logic [16:0] num;
	logic [30:0] pri_d;
	logic [CW:0] trial;
	logic        ge;
	logic        new_pkt, cur_tail_pkt;
	logic [CW-1:0] size, cur_left;
	logic [31:0] cur_pid;

	assign fb_eff    = (flit_bytes_q == '0) ? 7'd1 : flit_bytes_q;
	assign mp_eff    = (max_pkt_q == '0) ? 7'd1 : max_pkt_q;
	assign bad_dst   = (in_data.dst_node >= 7'(NODES));
	assign max_bytes = 16'(MAX_MSG_FLITS) * {9'd0, fb_eff};
	assign too_long  = (in_data.payload_len > max_bytes);
	// rounded-up numerator; when in range it is below 2^CW * fb
	assign num       = {1'b0, in_data.payload_len} + {10'd0, fb_eff} - 17'd1;
	assign cls_sel   = (CLASSES > 1) ? in_data.traffic_class : 1'b0;

	always_comb begin
		case (prio_mode_q)
			mfs_pkg::PRIO_CLASS: pri_d = {15'd0, cls_sel ? class1_prio_q : class0_prio_q};
			mfs_pkg::PRIO_AGE:   pri_d = ~in_data.inject_time;
			mfs_pkg::PRIO_SEQ:   pri_d = ~in_data.source_seq;
			default:             pri_d = '0;
		endcase
	end

	assign trial = {prem_q, dvd_q[CW-1]};
	assign ge    = (trial >= {1'b0, fb_eff});

	assign new_pkt      = (pkt_left_q == '0);
	assign size         = (rem_q > mp_eff) ? mp_eff : rem_q;
	assign cur_left     = new_pkt ? size : pkt_left_q;
	assign cur_tail_pkt = new_pkt ? (rem_q <= mp_eff) : pkt_tail_q;
	assign cur_pid      = new_pkt ? next_pid_q : pid_q;

	assign sts.err      = (status_q != mfs_pkg::ST_OK);
	assign sts.last     = (rem_q == CW'(1));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flit_bytes_q  <= 7'd16;
			max_pkt_q     <= 7'd4;
			prio_mode_q   <= mfs_pkg::PRIO_ZERO;
			class0_prio_q <= '0;
			class1_prio_q <= '0;
			write_mark_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mfs_pkg::REG_FLIT_BYTES:    flit_bytes_q  <= cfg_wdata[6:0];
				mfs_pkg::REG_MAX_PKT_FLITS: max_pkt_q     <= cfg_wdata[6:0];
				mfs_pkg::REG_PRIO_MODE:     prio_mode_q   <= cfg_wdata[1:0];
				mfs_pkg::REG_CLASS0_PRIO:   class0_prio_q <= cfg_wdata;
				mfs_pkg::REG_CLASS1_PRIO:   class1_prio_q <= cfg_wdata;
				mfs_pkg::REG_WRITE_MARK:    write_mark_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// payload latch and divider, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q    <= in_data.src_node;
			dst_q    <= in_data.dst_node[5:0];
			cls_q    <= in_data.traffic_class;
			time_q   <= in_data.inject_time;
			pri_q    <= pri_d;
			zero_q   <= (in_data.payload_len == '0);
			status_q <= bad_dst ? mfs_pkg::ST_BAD_DST :
			            too_long ? mfs_pkg::ST_TOO_LONG : mfs_pkg::ST_OK;
			prem_q   <= CW'(num[16:CW]);
			dvd_q    <= num[CW-1:0];
			quo_q    <= '0;
		end else if (cmd.step) begin
			prem_q <= CW'(ge ? trial - {1'b0, fb_eff} : trial);
			quo_q  <= {quo_q[CW-2:0], ge};
			dvd_q  <= {dvd_q[CW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			pkt_left_q <= '0;
			pkt_tail_q <= 1'b0;
			pkt_head_q <= 1'b0;
			pid_q      <= '0;
			next_pid_q <= '0;
			next_fid_q <= '0;
		end else if (cmd.prep) begin
			rem_q      <= zero_q ? CW'(1) : quo_q;
			pkt_left_q <= '0;
			pkt_head_q <= 1'b1;
		end else if (cmd.emit) begin
			rem_q      <= rem_q - 1'b1;
			pkt_left_q <= cur_left - 1'b1;
			pkt_tail_q <= cur_tail_pkt;
			pid_q      <= cur_pid;
			next_fid_q <= next_fid_q + 1'b1;
			if (new_pkt) next_pid_q <= next_pid_q + 1'b1;
			if (cur_left == CW'(1)) pkt_head_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.flit_id       <= next_fid_q;
			out_q.packet_id     <= cur_pid;
			out_q.out_src       <= src_q;
			out_q.out_dst       <= dst_q;
			out_q.out_class     <= cls_q;
			out_q.flit_flags    <= {cur_tail_pkt, pkt_head_q, cur_left == CW'(1), new_pkt};
			out_q.packet_flits  <= new_pkt ? 7'(size) : 7'd0;
			out_q.flit_priority <= pri_q;
			out_q.is_write      <= write_mark_q;
			out_q.created_time  <= time_q;
			out_q.status        <= mfs_pkg::ST_OK;
		end else if (cmd.emit_err) begin
			out_q.flit_id       <= '0;
			out_q.packet_id     <= '0;
			out_q.out_src       <= src_q;
			out_q.out_dst       <= '0;
			out_q.out_class     <= cls_q;
			out_q.flit_flags    <= '0;
			out_q.packet_flits  <= '0;
			out_q.flit_priority <= '0;
			out_q.is_write      <= 1'b0;
			out_q.created_time  <= time_q;
			out_q.status        <= status_q;
		end
	end

	`MFS_ASSERT_IMP(a_last_closes_pkt, clk, arst_n, cmd.emit && rem_q == CW'(1), cur_left == CW'(1) && cur_tail_pkt, "last flit of message does not close its packet")
	`MFS_ASSERT_IMP(a_pkt_nonempty, clk, arst_n, cmd.emit && new_pkt, size != '0, "empty packet started")
	`MFS_ASSERT_IMP(a_pkt_within_msg, clk, arst_n, cmd.emit, cur_left <= rem_q && rem_q != '0, "packet runs past message end")

endmodule

### rtl/message_flit_segmenter_top.sv
// Message flit segmenter: a message request enters on the input channel
// (in_valid / in_stall, word in_data) and leaves as flit words on the
// output channel (out_valid / out_stall, word out_data).
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while idle; the block itself does not enforce it.
// Sequence: after a request is taken, a shift-subtract divide works out
// the flit count, a setup step loads the packet counters, then one flit
// word is loaded per cycle into the output register whenever it is free.
// A rejected message (bad destination or too long) yields one status
// word in place of flits.
// in_stall is high from accept until the last word has been loaded into
// the output register.
// While out_valid and out_stall are high the word holds and emission pauses.
// Reset clears config to defaults, zeroes the flit and packet id counters
// and leaves the block idle with out_valid low.
// Depends on mfs_pkg, mfs_ctrl and mfs_datapath.
`timescale 1ns / 1ps

module message_flit_segmenter_top #(
	parameter int NODES         = mfs_pkg::NODES_DEF,
	parameter int CLASSES       = mfs_pkg::CLASSES_DEF,
	parameter int MAX_MSG_FLITS = mfs_pkg::MAX_MSG_FLITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mfs_pkg::IDX_W-1:0] cfg_index,
	input  logic [mfs_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  mfs_pkg::mfs_in_t          in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output mfs_pkg::mfs_out_t         out_data
);

	mfs_pkg::mfs_cmd_t cmd;
	mfs_pkg::mfs_sts_t sts;

	mfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mfs_datapath #(
		.NODES         (NODES),
		.CLASSES       (CLASSES),
		.MAX_MSG_FLITS (MAX_MSG_FLITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
